### hdl/assert_macros.svh
// Assertion helpers used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hdl/bsa_pkg.sv
`default_nettype none
package bsa_pkg;
	localparam int CUSTOMERS      = 5;
	localparam int RESOURCE_TYPES = 4;
	localparam int COUNT_BITS     = 8;
	localparam int CUST_BITS      = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
	localparam int RT_BITS        = (RESOURCE_TYPES > 1) ? $clog2(RESOURCE_TYPES) : 1;
	localparam int PASS_BITS      = $clog2(CUSTOMERS + 1);
	// The work vector holds the pool plus everything every customer holds.
	localparam int WORK_BITS      = COUNT_BITS + $clog2(CUSTOMERS + 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef count_t [RESOURCE_TYPES-1:0] vec_t;

	typedef enum logic [1:0] {
		FN_REQUEST = 2'd0,
		FN_RELEASE = 2'd1,
		FN_SET_MAX = 2'd2,
		FN_NONE    = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_DONE       = 3'd0,
		ST_SHORT      = 3'd1,
		ST_OVER_NEED  = 3'd2,
		ST_UNSAFE     = 3'd3,
		ST_BAD_CUST   = 3'd4,
		ST_OVER_ALLOC = 3'd5,
		ST_MAX_LOW    = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_CHECK,
		S_PASS_END,
		S_OUT
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load;       // capture the input item
		logic eval;       // precheck and apply tentative change
		logic chk_init;   // start safety check
		logic chk_step;   // visit one customer
		logic pass_clr;   // clear progress flag for a new pass
		logic rollback;   // undo tentative grant
	} dp_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic need_check; // evaluated item is a request that passed prechecks
		logic last_cust;  // current visit is the last customer
		logic all_done;   // every customer finished
		logic progress;   // a customer finished in this pass
		logic last_pass;  // pass counter at its final pass
	} dp_stat_t;
endpackage
`default_nettype wire

### hdl/bankers_safe_allocator_top.sv
// Banker's-algorithm resource allocator.
// Input channel (valid/ready): func, customer and four amounts per item.
// Output channel (valid/ready): one result item per input item with the
// status code and the four available counts after the operation.
// Configuration: APB writes at byte addresses 0, 4, 8, 12 set the starting
// available count of each resource type and load that count directly.
// Sequence: release, set-max, failing and bad-customer items go from the
// evaluation state straight to the result state. A request that reaches the
// safety check adds up to CUSTOMERS passes, each visiting every customer in
// turn in the check state and closing in the pass-end state.
// One item is handled at a time; ready is low from acceptance until its
// result is taken. A stalled result holds its payload, except that an APB
// write to a configuration register also changes that available count.
// Reset clears all held and need counts, the available counts and the
// configuration registers to zero.
`default_nettype none
`include "assert_macros.svh"
module bankers_safe_allocator_top import bsa_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [2:0]  customer,
	input  wire logic [7:0]  amount_0,
	input  wire logic [7:0]  amount_1,
	input  wire logic [7:0]  amount_2,
	input  wire logic [7:0]  amount_3,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [7:0]       avail_0,
	output logic [7:0]       avail_1,
	output logic [7:0]       avail_2,
	output logic [7:0]       avail_3,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	dp_cmd_t cmd;
	dp_stat_t stat;
	logic busy, cfg_we, in_fire, out_fire;
	vec_t amount, avail;
	logic [7:0] init_q [4];

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign in_ready = !busy;
	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign amount = {amount_3, amount_2, amount_1, amount_0};
	assign avail_0 = avail[0];
	assign avail_1 = avail[1];
	assign avail_2 = avail[2];
	assign avail_3 = avail[3];

	// Starting availability registers, readable over APB.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) init_q[i] <= '0;
		end else if (cfg_we) begin
			init_q[paddr[3:2]] <= pwdata[7:0];
		end
	end
	assign prdata = {24'd0, init_q[paddr[3:2]]};

	bsa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.stat(stat), .cmd(cmd), .busy(busy), .out_valid(out_valid)
	);

	bsa_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.func(func), .customer(customer), .amount(amount),
		.cfg_we(cfg_we), .cfg_idx(paddr[3:2]), .cfg_data(pwdata[7:0]),
		.avail(avail), .status(status)
	);

	`ASSERT_IMPL(a_no_accept_while_result, clk, arst_n, out_valid, !in_ready)
	`ASSERT_NEXT(a_accept_then_busy, clk, arst_n, in_fire, !in_ready && !out_valid)
	`ASSERT_IMPL(a_rollback_in_check, clk, arst_n, cmd.rollback, !cmd.eval && !cmd.load)
endmodule
`default_nettype wire

### hdl/bsa_ctrl.sv
`default_nettype none
module bsa_ctrl import bsa_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_fire,
	input  wire logic     out_fire,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd,
	output logic          busy,
	output logic          out_valid
);
	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_fire) state_d = S_EVAL;
			S_EVAL:  state_d = stat.need_check ? S_CHECK : S_OUT;
			S_CHECK: if (stat.last_cust) state_d = S_PASS_END;
			S_PASS_END: begin
				if (stat.all_done || !stat.progress || stat.last_pass) state_d = S_OUT;
				else state_d = S_CHECK;
			end
			S_OUT:   if (out_fire) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd = '0;
		busy = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				cmd.load = in_fire;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				cmd.chk_init = stat.need_check;
			end
			S_CHECK: cmd.chk_step = 1'b1;
			S_PASS_END: begin
				cmd.pass_clr = 1'b1;
				cmd.rollback = !stat.all_done && !stat.progress;
			end
			S_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

### hdl/bsa_datapath.sv
`default_nettype none
module bsa_datapath import bsa_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dp_cmd_t     cmd,
	output dp_stat_t         stat,
	input  wire logic [1:0]  func,
	input  wire logic [2:0]  customer,
	input  wire vec_t        amount,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [7:0]  cfg_data,
	output vec_t             avail,
	output logic [2:0]       status
);
	vec_t held_q [CUSTOMERS];
	vec_t need_q [CUSTOMERS];
	vec_t avail_q, amt_q;
	logic [RESOURCE_TYPES-1:0][WORK_BITS-1:0] work_q;
	logic [CUSTOMERS-1:0] fin_q;
	logic [CUST_BITS-1:0] cu_q, vis_q;
	logic [2:0] cust_raw_q;
	logic [1:0] func_q;
	logic [PASS_BITS-1:0] pass_q;
	logic progress_q;
	status_t status_q;

	assign avail = avail_q;
	assign status = status_q;

	// Precheck of the captured item.
	logic bad_cust, short_av, over_need, over_alloc, max_low;
	always_comb begin
		bad_cust = ({1'b0, cust_raw_q} >= 4'(CUSTOMERS));
		short_av = 1'b0; over_need = 1'b0; over_alloc = 1'b0; max_low = 1'b0;
		for (int r = 0; r < RESOURCE_TYPES; r++) begin
			if (amt_q[r] > avail_q[r]) short_av = 1'b1;
			if (amt_q[r] > need_q[cu_q][r]) over_need = 1'b1;
			if (amt_q[r] > held_q[cu_q][r]) over_alloc = 1'b1;
			if (amt_q[r] < held_q[cu_q][r]) max_low = 1'b1;
		end
	end

	// Fit test of the customer being visited.
	logic fits;
	always_comb begin
		fits = !fin_q[vis_q];
		for (int r = 0; r < RESOURCE_TYPES; r++)
			if (WORK_BITS'(need_q[vis_q][r]) > work_q[r]) fits = 1'b0;
	end

	assign stat.need_check = !bad_cust && func_q == FN_REQUEST && !short_av && !over_need;
	assign stat.last_cust  = (vis_q == CUST_BITS'(CUSTOMERS - 1));
	assign stat.all_done   = &fin_q;
	assign stat.progress   = progress_q;
	assign stat.last_pass  = (pass_q == PASS_BITS'(CUSTOMERS - 1));

	// Saturating add.
	function automatic count_t sat_add(count_t a, count_t b);
		logic [COUNT_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
	endfunction

	// Control state of the safety check.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q <= '0; vis_q <= '0; pass_q <= '0; progress_q <= 1'b0;
		end else begin
			if (cmd.chk_init) begin
				fin_q <= '0; vis_q <= '0; pass_q <= '0; progress_q <= 1'b0;
			end else if (cmd.chk_step) begin
				if (fits) begin
					fin_q[vis_q] <= 1'b1;
					progress_q <= 1'b1;
				end
				vis_q <= stat.last_cust ? '0 : vis_q + 1'b1;
			end else if (cmd.pass_clr) begin
				progress_q <= 1'b0;
				pass_q <= pass_q + 1'b1;
			end
		end
	end

	// Counts: configuration loads, item application and rollback.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avail_q <= '0;
			for (int c = 0; c < CUSTOMERS; c++) begin
				held_q[c] <= '0; need_q[c] <= '0;
			end
		end else begin
			if (cfg_we && {1'b0, cfg_idx} < 3'(RESOURCE_TYPES))
				avail_q[cfg_idx[RT_BITS-1:0]] <= cfg_data[COUNT_BITS-1:0];
			if (cmd.eval && !bad_cust) begin
				unique case (func_t'(func_q))
					FN_REQUEST: if (stat.need_check) begin
						for (int r = 0; r < RESOURCE_TYPES; r++) begin
							avail_q[r] <= avail_q[r] - amt_q[r];
							need_q[cu_q][r] <= need_q[cu_q][r] - amt_q[r];
							held_q[cu_q][r] <= held_q[cu_q][r] + amt_q[r];
						end
					end
					FN_RELEASE: if (!over_alloc) begin
						for (int r = 0; r < RESOURCE_TYPES; r++) begin
							avail_q[r] <= sat_add(avail_q[r], amt_q[r]);
							need_q[cu_q][r] <= sat_add(need_q[cu_q][r], amt_q[r]);
							held_q[cu_q][r] <= held_q[cu_q][r] - amt_q[r];
						end
					end
					FN_SET_MAX: if (!max_low) begin
						for (int r = 0; r < RESOURCE_TYPES; r++)
							need_q[cu_q][r] <= amt_q[r] - held_q[cu_q][r];
					end
					FN_NONE: ;
					default: ;
				endcase
			end
			if (cmd.rollback) begin
				for (int r = 0; r < RESOURCE_TYPES; r++) begin
					avail_q[r] <= avail_q[r] + amt_q[r];
					need_q[cu_q][r] <= need_q[cu_q][r] + amt_q[r];
					held_q[cu_q][r] <= held_q[cu_q][r] - amt_q[r];
				end
			end
		end
	end

	// Payload registers: captured item, work vector, status.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			cust_raw_q <= customer;
			cu_q <= customer[CUST_BITS-1:0];
			amt_q <= amount;
		end
		// Work vector starts from the granted availability.
		if (cmd.chk_init)
			for (int r = 0; r < RESOURCE_TYPES; r++)
				work_q[r] <= WORK_BITS'(avail_q[r] - amt_q[r]);
		else if (cmd.chk_step && fits)
			for (int r = 0; r < RESOURCE_TYPES; r++)
				work_q[r] <= work_q[r] + WORK_BITS'(held_q[vis_q][r]);
		if (cmd.eval) begin
			priority if (bad_cust) status_q <= ST_BAD_CUST;
			else if (func_q == FN_REQUEST)
				status_q <= short_av ? ST_SHORT : (over_need ? ST_OVER_NEED : ST_DONE);
			else if (func_q == FN_RELEASE) status_q <= over_alloc ? ST_OVER_ALLOC : ST_DONE;
			else if (func_q == FN_SET_MAX) status_q <= max_low ? ST_MAX_LOW : ST_DONE;
			else status_q <= ST_DONE;
		end else if (cmd.rollback) status_q <= ST_UNSAFE;
	end
endmodule
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import bsa_pkg::*;

	localparam int ITEMS_RANDOM = 530;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;

	// Clock, reset and all block ports.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	wire logic   in_ready;
	logic [1:0]  func = '0;
	logic [2:0]  customer = '0;
	logic [7:0]  amount_0 = '0, amount_1 = '0, amount_2 = '0, amount_3 = '0;
	wire logic   out_valid;
	logic        out_ready = 1'b0;
	wire logic [2:0] status;
	wire logic [7:0] avail_0, avail_1, avail_2, avail_3;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire logic [31:0] prdata;
	wire logic   pready;

	bankers_safe_allocator_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .customer(customer),
		.amount_0(amount_0), .amount_1(amount_1),
		.amount_2(amount_2), .amount_3(amount_3),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status),
		.avail_0(avail_0), .avail_1(avail_1), .avail_2(avail_2), .avail_3(avail_3),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// One expected result item of the allocator.
	typedef struct {
		status_t st;
		vec_t    pool;
	} grant_result_t;

	// One item of stimulus; check_fixed marks rows with a typed-in answer.
	typedef struct {
		func_t   fn;
		logic [2:0] cust;
		vec_t    amt;
		logic    check_fixed;
		grant_result_t fixed;
	} alloc_item_t;

	grant_result_t pending_results[$];
	alloc_item_t   stim_rows[$];
	int  errors = 0;
	int  cycles = 0;
	bit  idle_off = 1'b0;
	bit  hold_long = 1'b0;

	// Local copy of the allocator state.
	vec_t pool_left;
	vec_t holding [CUSTOMERS];
	vec_t claim_left [CUSTOMERS];

	function automatic void clear_ledger();
		pool_left = '0;
		for (int c = 0; c < CUSTOMERS; c++) begin
			holding[c] = '0;
			claim_left[c] = '0;
		end
	endfunction

	// Banker's safety test: repeatedly retire any customer whose need fits.
	function automatic bit ledger_safe();
		int   work [RESOURCE_TYPES];
		bit   done_c [CUSTOMERS];
		bit   moved, fits, all_done;
		for (int r = 0; r < RESOURCE_TYPES; r++) work[r] = pool_left[r];
		for (int c = 0; c < CUSTOMERS; c++) done_c[c] = 1'b0;
		for (int p = 0; p < CUSTOMERS; p++) begin
			moved = 1'b0;
			for (int c = 0; c < CUSTOMERS; c++) begin
				if (!done_c[c]) begin
					fits = 1'b1;
					for (int r = 0; r < RESOURCE_TYPES; r++)
						if (claim_left[c][r] > work[r]) fits = 1'b0;
					if (fits) begin
						for (int r = 0; r < RESOURCE_TYPES; r++) work[r] += holding[c][r];
						done_c[c] = 1'b1;
						moved = 1'b1;
					end
				end
			end
			all_done = 1'b1;
			for (int c = 0; c < CUSTOMERS; c++) if (!done_c[c]) all_done = 1'b0;
			if (all_done) return 1'b1;
			if (!moved) return 1'b0;
		end
		return 1'b1;
	endfunction

	// Applies one item to the local state and returns the expected result.
	function automatic grant_result_t apply_item(alloc_item_t it);
		grant_result_t res;
		int c, s;
		c = it.cust;
		res.st = ST_DONE;
		if (it.cust >= CUSTOMERS) begin
			res.st = ST_BAD_CUST;
		end else if (it.fn == FN_REQUEST) begin
			for (int r = 0; r < RESOURCE_TYPES; r++)
				if (res.st == ST_DONE && it.amt[r] > pool_left[r]) res.st = ST_SHORT;
			for (int r = 0; r < RESOURCE_TYPES; r++)
				if (res.st == ST_DONE && it.amt[r] > claim_left[c][r]) res.st = ST_OVER_NEED;
			if (res.st == ST_DONE) begin
				for (int r = 0; r < RESOURCE_TYPES; r++) begin
					pool_left[r] -= it.amt[r];
					claim_left[c][r] -= it.amt[r];
					holding[c][r] += it.amt[r];
				end
				if (!ledger_safe()) begin
					for (int r = 0; r < RESOURCE_TYPES; r++) begin
						pool_left[r] += it.amt[r];
						claim_left[c][r] += it.amt[r];
						holding[c][r] -= it.amt[r];
					end
					res.st = ST_UNSAFE;
				end
			end
		end else if (it.fn == FN_RELEASE) begin
			for (int r = 0; r < RESOURCE_TYPES; r++)
				if (it.amt[r] > holding[c][r]) res.st = ST_OVER_ALLOC;
			if (res.st == ST_DONE) begin
				for (int r = 0; r < RESOURCE_TYPES; r++) begin
					s = pool_left[r] + it.amt[r];
					pool_left[r] = (s > COUNT_MAX) ? COUNT_MAX : count_t'(s);
					s = claim_left[c][r] + it.amt[r];
					claim_left[c][r] = (s > COUNT_MAX) ? COUNT_MAX : count_t'(s);
					holding[c][r] -= it.amt[r];
				end
			end
		end else if (it.fn == FN_SET_MAX) begin
			for (int r = 0; r < RESOURCE_TYPES; r++)
				if (it.amt[r] < holding[c][r]) res.st = ST_MAX_LOW;
			if (res.st == ST_DONE)
				for (int r = 0; r < RESOURCE_TYPES; r++)
					claim_left[c][r] = it.amt[r] - holding[c][r];
		end
		res.pool = pool_left;
		return res;
	endfunction

	// Register write over the configuration port; also loads the pool count.
	task automatic write_initial(int idx, logic [7:0] value);
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
		paddr = 4'(4 * idx); pwdata = {$urandom_range(0, 1) ? 24'hFFFFFF : 24'h0, value};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx < RESOURCE_TYPES) pool_left[idx] = value;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	task automatic write_pool(vec_t v);
		for (int r = 0; r < RESOURCE_TYPES; r++) write_initial(r, v[r]);
	endtask

	// Waits until every expected result has come back and the block is idle.
	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic alloc_item_t make_item(func_t fn, int cust, vec_t amt);
		alloc_item_t it;
		it.fn = fn; it.cust = 3'(cust); it.amt = amt;
		it.check_fixed = 1'b0;
		it.fixed.st = ST_DONE; it.fixed.pool = '0;
		return it;
	endfunction

	function automatic alloc_item_t make_fixed(func_t fn, int cust, vec_t amt,
			status_t st, vec_t pool);
		alloc_item_t it;
		it = make_item(fn, cust, amt);
		it.check_fixed = 1'b1;
		it.fixed.st = st; it.fixed.pool = pool;
		return it;
	endfunction

	function automatic vec_t rand_vec(int hi);
		vec_t v;
		for (int r = 0; r < RESOURCE_TYPES; r++) v[r] = count_t'($urandom_range(0, hi));
		return v;
	endfunction

	// Sends one item, with a random idle burst before it unless idling is off.
	task automatic send_item(alloc_item_t it);
		grant_result_t res;
		if (!idle_off && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 7)) @(negedge clk);
		in_valid = 1'b1;
		func = it.fn; customer = it.cust;
		amount_0 = it.amt[0]; amount_1 = it.amt[1];
		amount_2 = it.amt[2]; amount_3 = it.amt[3];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		res = apply_item(it);
		if (it.check_fixed && (res.st != it.fixed.st || res.pool != it.fixed.pool)) begin
			$display("%0t: table row disagrees: expected %0d %h, predicted %0d %h",
				$time, it.fixed.st, it.fixed.pool, res.st, res.pool);
			errors++;
		end
		if (it.check_fixed) res = it.fixed;
		pending_results.push_back(res);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Receiver side: random stalls and one long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_long) begin
				out_ready = 1'b0;
				repeat (300) @(negedge clk);
				hold_long = 1'b0;
			end
			if (!idle_off && $urandom_range(0, 4) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	// Result checking against the oldest expected item.
	always @(posedge clk) begin
		grant_result_t exp_res;
		vec_t got;
		if (arst_n && out_valid && out_ready) begin
			got = {avail_3, avail_2, avail_1, avail_0};
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result item status %0d avail %h", $time, status, got);
				errors++;
			end else begin
				exp_res = pending_results.pop_front();
				if (status != exp_res.st) begin
					$display("%0t: status expected %0d actual %0d", $time, exp_res.st, status);
					errors++;
				end
				for (int r = 0; r < RESOURCE_TYPES; r++)
					if (got[r] != exp_res.pool[r]) begin
						$display("%0t: avail_%0d expected %0d actual %0d",
							$time, r, exp_res.pool[r], got[r]);
						errors++;
					end
			end
		end
	end

	// Cycle limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Main stimulus.
	initial begin
		alloc_item_t it;
		int c, pick;
		vec_t v;
		clear_ledger();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// After reset every pool count is zero.
		stim_rows.push_back(make_fixed(FN_REQUEST, 0, '0, ST_DONE, '0));
		stim_rows.push_back(make_fixed(FN_REQUEST, 1, {4{8'd1}}, ST_SHORT, '0));
		stim_rows.push_back(make_fixed(FN_NONE, 2, {4{8'hFF}}, ST_DONE, '0));
		stim_rows.push_back(make_fixed(FN_SET_MAX, 5, {4{8'hFF}}, ST_BAD_CUST, '0));
		stim_rows.push_back(make_fixed(FN_RELEASE, 7, '0, ST_BAD_CUST, '0));
		stim_rows.push_back(make_fixed(FN_RELEASE, 3, {4{8'd1}}, ST_OVER_ALLOC, '0));
		foreach (stim_rows[i]) send_item(stim_rows[i]);
		stim_rows.delete();
		drain();

		// Full pool: grants, over-need, unsafe, releases and max below held.
		write_pool({4{8'hFF}});
		stim_rows.push_back(make_fixed(FN_SET_MAX, 0, {4{8'hFF}}, ST_DONE, {4{8'hFF}}));
		stim_rows.push_back(make_item(FN_SET_MAX, 1, {4{8'hFF}}));
		stim_rows.push_back(make_item(FN_REQUEST, 0, {4{8'h80}}));
		stim_rows.push_back(make_item(FN_REQUEST, 1, {4{8'h7F}}));
		stim_rows.push_back(make_item(FN_REQUEST, 2, {4{8'h01}}));
		stim_rows.push_back(make_item(FN_REQUEST, 0, {4{8'h7F}}));
		stim_rows.push_back(make_item(FN_SET_MAX, 0, {4{8'h10}}));
		stim_rows.push_back(make_item(FN_RELEASE, 0, {4{8'h80}}));
		stim_rows.push_back(make_item(FN_RELEASE, 1, {4{8'h7F}}));
		stim_rows.push_back(make_item(FN_SET_MAX, 4, {8'h00, 8'h55, 8'hAA, 8'hFF}));
		stim_rows.push_back(make_item(FN_REQUEST, 4, {8'h00, 8'h55, 8'hAA, 8'hFF}));
		stim_rows.push_back(make_item(FN_RELEASE, 4, {8'h00, 8'h55, 8'hAA, 8'hFF}));
		foreach (stim_rows[i]) send_item(stim_rows[i]);
		stim_rows.delete();
		drain();

		// Shrinking the pool mid-run lets a release saturate the counts.
		write_pool({8'h00, 8'h01, 8'hFE, 8'hFF});
		send_item(make_item(FN_SET_MAX, 3, {4{8'h40}}));
		send_item(make_item(FN_REQUEST, 3, {8'h00, 8'h01, 8'h20, 8'h40}));
		drain();
		write_pool({4{8'hF0}});
		send_item(make_item(FN_RELEASE, 3, {8'h00, 8'h01, 8'h20, 8'h40}));
		drain();

		// Random part: mostly claims and requests within the claims.
		// Held and claimed counts carry over; only the pool is reloaded.
		for (int n = 0; n < ITEMS_RANDOM; n++) begin
			if (n % 130 == 0) begin
				drain();
				write_pool(n == 260 ? vec_t'('0) : rand_vec(n == 390 ? 255 : 40));
			end
			if (n == 200) hold_long = 1'b1;
			if (n >= ITEMS_RANDOM - 60) idle_off = 1'b1;
			c = $urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(0, 4);
			pick = $urandom_range(0, 19);
			if (pick < 4) begin
				it = make_item(FN_SET_MAX, c, rand_vec(pick == 0 ? 255 : 30));
			end else if (pick < 12) begin
				for (int r = 0; r < RESOURCE_TYPES; r++)
					v[r] = (c < CUSTOMERS) ? count_t'($urandom_range(0, claim_left[c][r]))
						: count_t'($urandom);
				it = make_item(FN_REQUEST, c, pick == 11 ? rand_vec(255) : v);
			end else if (pick < 17) begin
				for (int r = 0; r < RESOURCE_TYPES; r++)
					v[r] = (c < CUSTOMERS) ? count_t'($urandom_range(0, holding[c][r]))
						: count_t'($urandom);
				it = make_item(FN_RELEASE, c, pick == 16 ? rand_vec(255) : v);
			end else begin
				it = make_item(func_t'($urandom_range(0, 3)), c, rand_vec(255));
			end
			send_item(it);
		end

		// Let the last results come back.
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire

### filelist.f
+incdir+hdl
hdl/bsa_pkg.sv
hdl/bsa_ctrl.sv
hdl/bsa_datapath.sv
hdl/bankers_safe_allocator_top.sv
test/testbench.sv
